// ===== design/bslp_pkg.sv =====
`default_nettype none

package bslp_pkg;

  // Field widths
  localparam int unsigned RunW  = 8;
  localparam int unsigned TickW = 16;
  localparam int unsigned CfgW  = 16;
  localparam int unsigned IdxW  = 3;

  // Saturation limits
  localparam logic [RunW-1:0]  RunMax  = {RunW{1'b1}};
  localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};

  // Register reset values
  localparam logic             ActiveLowRst = 1'b1;
  localparam logic [RunW-1:0]  DebounceRst  = 8'd3;
  localparam logic [TickW-1:0] LongRst      = 16'd50;
  localparam logic [TickW-1:0] GuardRst     = 16'd250;
  localparam logic [TickW-1:0] BlinkRst     = 16'd25;

  // Register indexes
  typedef enum logic [IdxW-1:0] {
    CFG_ACTIVE_LOW  = 3'd0,
    CFG_DEBOUNCE    = 3'd1,
    CFG_LONG_TICKS  = 3'd2,
    CFG_GUARD_TICKS = 3'd3,
    CFG_BLINK_TICKS = 3'd4
  } cfg_idx_e;

  // Live configuration
  typedef struct packed {
    logic             active_low;
    logic [RunW-1:0]  debounce_count;
    logic [TickW-1:0] long_press_ticks;
    logic [TickW-1:0] guard_ticks;
    logic [TickW-1:0] blink_ticks;
  } cfg_t;

  // One result beat
  typedef struct packed {
    logic key_down;
    logic short_event;
    logic long_event;
    logic shutdown_latched;
    logic heartbeat_led;
  } res_t;

  // Saturating increment of a tick counter
  function automatic logic [TickW-1:0] sat_inc16(input logic [TickW-1:0] v);
    sat_inc16 = (v == TickMax) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== design/bslp_cfg_regs.sv =====
`default_nettype none

module bslp_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [bslp_pkg::IdxW-1:0]   cfg_idx_i,
  input  wire logic [bslp_pkg::CfgW-1:0]   cfg_data_i,
  output bslp_pkg::cfg_t                   cfg_o
);

  bslp_pkg::cfg_t cfg_q, cfg_d;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (bslp_pkg::cfg_idx_e'(cfg_idx_i))
        bslp_pkg::CFG_ACTIVE_LOW:  cfg_d.active_low       = cfg_data_i[0];
        bslp_pkg::CFG_DEBOUNCE:    cfg_d.debounce_count   = cfg_data_i[bslp_pkg::RunW-1:0];
        bslp_pkg::CFG_LONG_TICKS:  cfg_d.long_press_ticks = cfg_data_i[bslp_pkg::TickW-1:0];
        bslp_pkg::CFG_GUARD_TICKS: cfg_d.guard_ticks      = cfg_data_i[bslp_pkg::TickW-1:0];
        bslp_pkg::CFG_BLINK_TICKS: cfg_d.blink_ticks      = cfg_data_i[bslp_pkg::TickW-1:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_low       <= bslp_pkg::ActiveLowRst;
      cfg_q.debounce_count   <= bslp_pkg::DebounceRst;
      cfg_q.long_press_ticks <= bslp_pkg::LongRst;
      cfg_q.guard_ticks      <= bslp_pkg::GuardRst;
      cfg_q.blink_ticks      <= bslp_pkg::BlinkRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== design/bslp_core.sv =====
`default_nettype none

module bslp_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  bslp_pkg::cfg_t      cfg_i,
  input  wire logic           step_i,
  input  wire logic           pin_level_i,
  output bslp_pkg::res_t      res_o
);

  logic                        last_q, last_d;
  logic [bslp_pkg::RunW-1:0]   run_q, run_d;
  logic                        deb_q, deb_d;
  logic                        lf_q, lf_d;
  logic [bslp_pkg::TickW-1:0]  hold_q, hold_d;
  logic [bslp_pkg::TickW-1:0]  up_q, up_d;
  logic                        sd_q, sd_d;
  logic                        led_q, led_d;
  logic [bslp_pkg::TickW-1:0]  blink_q, blink_d;

  logic                        pressed;
  logic                        toggle;
  logic [bslp_pkg::TickW-1:0]  blink_base;
  logic                        trans;
  logic                        lf_mid;
  logic [bslp_pkg::TickW-1:0]  hold_mid;
  logic                        short_ev;
  logic                        long_ev;

  // Pin polarity
  assign pressed = cfg_i.active_low ? ~pin_level_i : pin_level_i;

  // Heartbeat toggle
  assign toggle     = (blink_q >= cfg_i.blink_ticks);
  assign led_d      = led_q ^ toggle;
  assign blink_base = toggle ? '0 : blink_q;

  // Run counter, restarts at one on a changed sample
  always_comb begin
    last_d = pressed;
    if (pressed == last_q) begin
      run_d = (run_q == bslp_pkg::RunMax) ? run_q : run_q + 1'b1;
    end else begin
      run_d = {{(bslp_pkg::RunW-1){1'b0}}, 1'b1};
    end
  end

  // Debounced transition and press classification
  assign trans    = (run_d >= cfg_i.debounce_count) && (pressed != deb_q);
  assign deb_d    = trans ? pressed : deb_q;
  assign lf_mid   = trans ? 1'b0 : lf_q;
  assign hold_mid = (trans && pressed) ? '0 : hold_q;
  assign short_ev = trans && !pressed && !lf_q && !sd_q;
  assign long_ev  = deb_d && !lf_mid && !sd_q &&
                    (up_q >= cfg_i.guard_ticks) && (hold_mid >= cfg_i.long_press_ticks);
  assign lf_d     = lf_mid | long_ev;
  assign sd_d     = sd_q | long_ev;

  // Saturating timers
  assign hold_d  = bslp_pkg::sat_inc16(hold_mid);
  assign up_d    = bslp_pkg::sat_inc16(up_q);
  assign blink_d = bslp_pkg::sat_inc16(blink_base);

  // Result of this beat, registered downstream
  always_comb begin
    res_o.key_down         = deb_d;
    res_o.short_event      = short_ev;
    res_o.long_event       = long_ev;
    res_o.shutdown_latched = sd_d;
    res_o.heartbeat_led    = led_d;
  end

  // State update once per accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= 1'b0;
      run_q   <= {{(bslp_pkg::RunW-1){1'b0}}, 1'b1};
      deb_q   <= 1'b0;
      lf_q    <= 1'b0;
      hold_q  <= '0;
      up_q    <= '0;
      sd_q    <= 1'b0;
      led_q   <= 1'b1;
      blink_q <= '0;
    end else if (step_i) begin
      last_q  <= last_d;
      run_q   <= run_d;
      deb_q   <= deb_d;
      lf_q    <= lf_d;
      hold_q  <= hold_d;
      up_q    <= up_d;
      sd_q    <= sd_d;
      led_q   <= led_d;
      blink_q <= blink_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/bslp_out_reg.sv =====
`default_nettype none

module bslp_out_reg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                step_o,
  input  bslp_pkg::res_t      res_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output bslp_pkg::res_t      res_o
);

  logic           valid_q, valid_d;
  bslp_pkg::res_t res_q;

  // Input waits only while a held result is stalled
  assign in_stall_o = valid_q & out_stall_i;
  assign step_o     = in_valid_i & ~in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (step_o) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (step_o) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== design/button_short_long_press_classifier_top.sv =====
// Debounced short/long key press classifier with heartbeat LED. Each input beat
// is one poll tick carrying the raw key pin level; each accepted beat yields
// exactly one result beat in the next cycle, from the result register. The block
// takes a beat every cycle: the state update is a single pass of narrow compare
// and increment logic, and the result register only holds off input while a
// finished result is stalled. Configuration writes take effect on the next beat
// and should be made while no result is pending.
`default_nettype none

module button_short_long_press_classifier_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [bslp_pkg::IdxW-1:0] cfg_idx_i,
  input  wire logic [bslp_pkg::CfgW-1:0] cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      pin_level_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic                           key_down_o,
  output logic                           short_event_o,
  output logic                           long_event_o,
  output logic                           shutdown_latched_o,
  output logic                           heartbeat_led_o
);

  bslp_pkg::cfg_t cfg;
  bslp_pkg::res_t res_next;
  bslp_pkg::res_t res_out;
  logic           step;

  bslp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bslp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (step),
    .pin_level_i (pin_level_i),
    .res_o       (res_next)
  );

  bslp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .step_o      (step),
    .res_i       (res_next),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_out)
  );

  assign key_down_o         = res_out.key_down;
  assign short_event_o      = res_out.short_event;
  assign long_event_o       = res_out.long_event;
  assign shutdown_latched_o = res_out.shutdown_latched;
  assign heartbeat_led_o    = res_out.heartbeat_led;

endmodule

`default_nettype wire

// ===== design/bslp_checker.sv =====
`default_nettype none

module bslp_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic key_down_o,
  input wire logic short_event_o,
  input wire logic long_event_o,
  input wire logic shutdown_latched_o,
  input wire logic heartbeat_led_o
);

  logic sd_seen_q;

  // Remember a delivered beat that showed shutdown
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd_seen_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && shutdown_latched_o) begin
      sd_seen_q <= 1'b1;
    end
  end

  // Shutdown stays latched until reset
  a_sd_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sd_seen_q) |-> shutdown_latched_o)
    else $error("shutdown flag dropped");

  // A long press fires on a held key and latches shutdown
  a_long_ctx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && long_event_o) |-> (key_down_o && shutdown_latched_o))
    else $error("long event without held key or shutdown");

  // Short and long never share a beat
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(short_event_o && long_event_o))
    else $error("short and long event together");

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(key_down_o) && $stable(short_event_o) &&
       $stable(long_event_o) && $stable(shutdown_latched_o) && $stable(heartbeat_led_o)))
    else $error("stalled result changed");

endmodule

bind button_short_long_press_classifier_top bslp_checker u_bslp_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .key_down_o         (key_down_o),
  .short_event_o      (short_event_o),
  .long_event_o       (long_event_o),
  .shutdown_latched_o (shutdown_latched_o),
  .heartbeat_led_o    (heartbeat_led_o)
);

`default_nettype wire
